[rtl/core/txbcs_pkg.sv]
// Package for the transmit byte credit shaper.
// Holds widths, reset values, register and mode codes and the sequencer state type.
// No dependencies.
package txbcs_pkg;

    localparam int DEF_QUEUE_DEPTH = 4096;

    localparam int CREDIT_W  = 17;
    localparam int CAP_W     = 13;
    localparam int DROP_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int BURST_W   = 6;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    // One byte costs 8 bits with 8 fraction bits, i.e. 2048 credit units.
    localparam int BYTE_COST_SHIFT = 11;

    localparam logic [CREDIT_W-1:0] CREDIT_MAX = '1;
    localparam logic [BURST_W-1:0]  MAX_BURST  = BURST_W'(57);
    localparam logic [DROP_W-1:0]   DROP_MAX   = '1;

    localparam logic [CREDIT_W-1:0] BPT_RESET = CREDIT_W'(2048);
    localparam logic [CAP_W-1:0]    CAP_RESET = CAP_W'(4096);

    typedef enum logic {
        REG_BITS_PER_TICK = 1'b0,
        REG_CAPACITY      = 1'b1
    } t_reg_idx;

    typedef enum logic {
        MODE_ENQUEUE = 1'b0,
        MODE_TICK    = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CREDIT,
        ST_SEND
    } t_state;

endpackage

[rtl/core/tx_byte_credit_shaper.sv]
// Transmit byte queue with a bit-credit rate shaper, top level.
// Depends on txbcs_pkg for widths, codes and the sequencer state type.
//
// Usage:
// The input channel (i_valid / o_ready) carries transactions of two kinds.
// An enqueue transaction (i_mode = 0) appends i_data_byte to the queue or,
// when the queue holds min(capacity_in_use, QUEUE_DEPTH) bytes or more, bumps a saturating drop
// counter; it produces no output and the block is ready again in the next cycle,
// so enqueues run at one per cycle.
// A tick transaction (i_mode = 1) refreshes the credit in ST_CREDIT and then
// sends up to 57 bytes on the output channel (o_valid / i_ready), one per cycle
// while the receiver takes them, the last one flagged by o_last. A tick that
// sends nothing yields one transaction with o_byte_valid low and o_last high.
// The first output of a tick is presented in ST_SEND, which follows the ST_CREDIT
// state entered when the tick is accepted; ST_SEND returns to idle once o_last is taken.
// The pace is set by the single read port of the queue memory, one byte per cycle.
// While the receiver stalls, the current output holds and no input is accepted.
// Reset empties the queue, clears credit and drop count and restores the
// registers to 2048 credit units (8 bits) per tick and a capacity of 4096 bytes.
// Registers (APB, pready always high): 0x0 bits_per_tick, 0x4 capacity_in_use.
module tx_byte_credit_shaper
    import txbcs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_mode,
    input  logic [BYTE_W-1:0]   i_data_byte,

    output logic                o_valid,
    input  logic                i_ready,
    output logic [BYTE_W-1:0]   o_out_byte,
    output logic                o_byte_valid,
    output logic                o_last,
    output logic [DROP_W-1:0]   o_dropped_count,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
    localparam int LIMW = (CNTW > CAP_W) ? CNTW : CAP_W;
    localparam int SUMW = ((PTRW > CNTW) ? PTRW : CNTW) + 1;
    localparam int BW   = (CNTW > BURST_W) ? CNTW : BURST_W;

    localparam logic [LIMW-1:0] DEPTH_L    = LIMW'(QUEUE_DEPTH);
    localparam logic [SUMW-1:0] DEPTH_S    = SUMW'(QUEUE_DEPTH);
    localparam logic [PTRW-1:0] PTR_LAST   = PTRW'(QUEUE_DEPTH - 1);

    // Configuration registers
    logic [CREDIT_W-1:0] r_bpt;
    logic [CAP_W-1:0]    r_cap;

    // Sequencer and queue state
    t_state              r_state, n_state;
    logic [PTRW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0]     r_count, n_count;
    logic [CREDIT_W-1:0] r_credit, n_credit;
    logic                r_empty, n_empty;
    logic [DROP_W-1:0]   r_drop, n_drop;
    logic [BURST_W-1:0]  r_burst, n_burst;

    logic [BYTE_W-1:0]   r_mem [QUEUE_DEPTH];
    logic [BYTE_W-1:0]   r_rd_data;

    logic                wr_en;
    logic [PTRW-1:0]     wr_addr;
    logic [PTRW-1:0]     rd_addr;
    logic [PTRW-1:0]     ptr_inc;
    logic [SUMW-1:0]     wr_sum;
    logic [LIMW-1:0]     limit;
    logic                has_room;
    logic                cfg_wr;

    logic [CREDIT_W-1:0] credit_base;
    logic [CREDIT_W:0]   credit_sum;
    logic [CREDIT_W-1:0] credit_sat;
    logic [BW-1:0]       burst_credit;
    logic [BW-1:0]       burst_fill;
    logic [BW-1:0]       burst_min;
    logic [BURST_W-1:0]  burst_new;

    // ---------------- Configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpt <= BPT_RESET;
            r_cap <= CAP_RESET;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_BITS_PER_TICK: r_bpt <= pwdata[CREDIT_W-1:0];
                REG_CAPACITY:      r_cap <= pwdata[CAP_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[2]))
            REG_BITS_PER_TICK: prdata = DATA_W'(r_bpt);
            REG_CAPACITY:      prdata = DATA_W'(r_cap);
        endcase
    end

    // ---------------- Queue addressing ----------------
    assign limit    = (LIMW'(r_cap) > DEPTH_L) ? DEPTH_L : LIMW'(r_cap);
    assign has_room = LIMW'(r_count) < limit;

    assign wr_sum  = SUMW'(r_rd_ptr) + SUMW'(r_count);
    assign wr_addr = (wr_sum >= DEPTH_S) ? PTRW'(wr_sum - DEPTH_S) : PTRW'(wr_sum);
    assign ptr_inc = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTRW'(1);

    // ---------------- Credit refresh ----------------
    assign credit_base = r_empty ? '0 : r_credit;
    assign credit_sum  = {1'b0, credit_base} + {1'b0, r_bpt};
    assign credit_sat  = credit_sum[CREDIT_W] ? CREDIT_MAX : credit_sum[CREDIT_W-1:0];

    assign burst_credit = BW'(credit_sat[CREDIT_W-1:BYTE_COST_SHIFT]);
    assign burst_fill   = BW'(r_count);
    assign burst_min    = (burst_credit < burst_fill) ? burst_credit : burst_fill;
    assign burst_new    = (burst_min > BW'(MAX_BURST)) ? MAX_BURST : BURST_W'(burst_min);

    // ---------------- Queue memory ----------------
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_data_byte;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // ---------------- Sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_credit <= '0;
            r_empty  <= 1'b1;
            r_drop   <= '0;
            r_burst  <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
            r_credit <= n_credit;
            r_empty  <= n_empty;
            r_drop   <= n_drop;
            r_burst  <= n_burst;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        n_credit = r_credit;
        n_empty  = r_empty;
        n_drop   = r_drop;
        n_burst  = r_burst;
        wr_en    = 1'b0;
        rd_addr  = r_rd_ptr;
        o_ready  = 1'b0;
        o_valid  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (t_mode'(i_mode) == MODE_TICK) begin
                        n_state = ST_CREDIT;
                    end else if (has_room) begin
                        wr_en   = 1'b1;
                        n_count = r_count + CNTW'(1);
                    end else if (r_drop != DROP_MAX) begin
                        n_drop = r_drop + DROP_W'(1);
                    end
                end
            end
            ST_CREDIT: begin
                n_credit = credit_sat - (CREDIT_W'(burst_new) << BYTE_COST_SHIFT);
                n_burst  = burst_new;
                n_state  = ST_SEND;
            end
            ST_SEND: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    // Read ahead at the next pointer so the following byte is ready
                    // in the very next cycle.
                    if (r_burst != '0) begin
                        n_rd_ptr = ptr_inc;
                        rd_addr  = ptr_inc;
                        n_count  = r_count - CNTW'(1);
                        n_burst  = r_burst - BURST_W'(1);
                    end
                    if (r_burst <= BURST_W'(1)) begin
                        n_state = ST_IDLE;
                        n_empty = (n_count == '0);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_byte_valid    = (r_burst != '0);
    assign o_out_byte      = o_byte_valid ? r_rd_data : '0;
    assign o_last          = (r_burst <= BURST_W'(1));
    assign o_dropped_count = r_drop;

`ifndef SYNTHESIS
    a_ready_excludes_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("input ready while a result is pending");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LIMW'(r_count) <= DEPTH_L)
        else $error("queue fill exceeds its depth");

    a_sent_byte_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_byte_valid) |-> (r_count != '0))
        else $error("byte sent from an empty queue");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> o_ready)
        else $error("block not ready after the final transaction of a tick");
`endif

endmodule
